/* src/press_hold_gear_shifter_assert.svh */
`ifndef PRESS_HOLD_GEAR_SHIFTER_ASSERT_SVH
`define PRESS_HOLD_GEAR_SHIFTER_ASSERT_SVH

// Same-cycle implication, checked at each rising clock edge out of reset.
`define PHGS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("press_hold_gear_shifter: assertion failed");

// Next-cycle implication, checked at each rising clock edge out of reset.
`define PHGS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("press_hold_gear_shifter: assertion failed");

`endif

/* src/phgs_pkg.sv */
package phgs_pkg;

    // Default limits on the number of chainrings and sprockets.
    localparam int MAX_FRONT_DEF = 5;
    localparam int MAX_REAR_DEF  = 20;

    // Field widths.
    localparam int OP_W     = 3;
    localparam int FREQ_W   = 4;
    localparam int RREQ_W   = 6;
    localparam int FRONT_W  = 3;
    localparam int REAR_W   = 5;
    localparam int GEAR_W   = 7;
    localparam int HOLD_W   = 16;
    // Clamped counts: one bit wider than the front and rear position fields.
    localparam int FCNT_W   = 4;
    localparam int RCNT_W   = 6;

    // Stream data widths.
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Reset values.
    localparam logic [FRONT_W-1:0] FRONT_COUNT_RST = 3'd3;
    localparam logic [REAR_W-1:0]  REAR_COUNT_RST  = 5'd10;
    localparam logic [HOLD_W-1:0]  HOLD_TICKS_RST  = 16'd200;
    localparam logic [FRONT_W-1:0] FRONT_POS_RST   = 3'd2;
    localparam logic [REAR_W-1:0]  REAR_POS_RST    = 5'd9;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRONT_COUNT = 2'd0,
        CFG_REAR_COUNT  = 2'd1,
        CFG_HOLD_TICKS  = 2'd2
    } t_cfg_idx;

    typedef enum logic [OP_W-1:0] {
        OP_TICK         = 3'd0,
        OP_UP_PRESS     = 3'd1,
        OP_UP_RELEASE   = 3'd2,
        OP_DOWN_PRESS   = 3'd3,
        OP_DOWN_RELEASE = 3'd4,
        OP_SET_GEAR     = 3'd5
    } t_op;

    // Effective configuration seen by the shifter core.
    typedef struct packed {
        logic [FCNT_W-1:0] front_count;
        logic [RCNT_W-1:0] rear_count;
        logic [HOLD_W-1:0] hold_ticks;
    } t_cfg;

    // Button status reported by the shifter core.
    typedef struct packed {
        logic              up_held;
        logic              down_held;
        logic              hold_done;
        logic [HOLD_W-1:0] hold_counter;
    } t_status;

endpackage

/* src/phgs_cfg.sv */
module phgs_cfg
    import phgs_pkg::*;
#(
    parameter int MAX_FRONT = MAX_FRONT_DEF,
    parameter int MAX_REAR  = MAX_REAR_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic [FRONT_W-1:0] r_front_count;
    logic [REAR_W-1:0]  r_rear_count;
    logic [HOLD_W-1:0]  r_hold_ticks;
    logic [FCNT_W-1:0]  front_wide;
    logic [RCNT_W-1:0]  rear_wide;

    // Register writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_count <= FRONT_COUNT_RST;
            r_rear_count  <= REAR_COUNT_RST;
            r_hold_ticks  <= HOLD_TICKS_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FRONT_COUNT: r_front_count <= i_cfg_data[FRONT_W-1:0];
                CFG_REAR_COUNT:  r_rear_count  <= i_cfg_data[REAR_W-1:0];
                CFG_HOLD_TICKS:  r_hold_ticks  <= i_cfg_data[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the counts into 1 .. maximum.
    always_comb begin
        front_wide = {1'b0, r_front_count};
        rear_wide  = {1'b0, r_rear_count};
        o_cfg.hold_ticks = r_hold_ticks;
        if (front_wide == '0) begin
            o_cfg.front_count = FCNT_W'(1);
        end else if (front_wide > FCNT_W'(MAX_FRONT)) begin
            o_cfg.front_count = FCNT_W'(MAX_FRONT);
        end else begin
            o_cfg.front_count = front_wide;
        end
        if (rear_wide == '0) begin
            o_cfg.rear_count = RCNT_W'(1);
        end else if (rear_wide > RCNT_W'(MAX_REAR)) begin
            o_cfg.rear_count = RCNT_W'(MAX_REAR);
        end else begin
            o_cfg.rear_count = rear_wide;
        end
    end

endmodule

/* src/phgs_core.sv */
module phgs_core
    import phgs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [OP_W-1:0]   i_op,
    input  logic [FREQ_W-1:0] i_front_request,
    input  logic [RREQ_W-1:0] i_rear_request,
    input  t_cfg              i_cfg,
    output logic [FRONT_W-1:0] o_front_index,
    output logic [REAR_W-1:0]  o_rear_index,
    output logic [GEAR_W-1:0]  o_gear_index,
    output logic               o_shift_done,
    output t_status            o_status
);

    logic               r_up_held,  n_up_held;
    logic               r_down_held, n_down_held;
    logic               r_hold_done, n_hold_done;
    logic [HOLD_W-1:0]  r_hold_counter, n_hold_counter;
    logic [FRONT_W-1:0] r_front_pos, n_front_pos;
    logic [REAR_W-1:0]  r_rear_pos, n_rear_pos;

    logic [HOLD_W-1:0]  count_inc;
    logic [FCNT_W-1:0]  front_plus;
    logic [RCNT_W-1:0]  rear_plus;
    logic [FRONT_W-1:0] front_inc, front_dec, front_load;
    logic [REAR_W-1:0]  rear_inc, rear_dec, rear_load;
    logic               shifted;
    logic [FRONT_W+RCNT_W-1:0] gear_prod;
    logic [FRONT_W+RCNT_W:0]   gear_sum;

    // Saturating moves and range-checked loads of both positions.
    always_comb begin
        count_inc  = r_hold_counter + HOLD_W'(1);
        front_plus = {1'b0, r_front_pos} + FCNT_W'(1);
        rear_plus  = {1'b0, r_rear_pos} + RCNT_W'(1);
        front_inc  = (front_plus >= i_cfg.front_count) ?
                     FRONT_W'(i_cfg.front_count - FCNT_W'(1)) : front_plus[FRONT_W-1:0];
        rear_inc   = (rear_plus >= i_cfg.rear_count) ?
                     REAR_W'(i_cfg.rear_count - RCNT_W'(1)) : rear_plus[REAR_W-1:0];
        front_dec  = (r_front_pos == '0) ? '0 : r_front_pos - FRONT_W'(1);
        rear_dec   = (r_rear_pos == '0) ? '0 : r_rear_pos - REAR_W'(1);
        // A negative request or one at or beyond the count loads zero.
        if (i_front_request[FREQ_W-1] ||
            ({1'b0, i_front_request[FREQ_W-2:0]} >= i_cfg.front_count)) begin
            front_load = '0;
        end else begin
            front_load = i_front_request[FRONT_W-1:0];
        end
        if (i_rear_request[RREQ_W-1] ||
            ({1'b0, i_rear_request[RREQ_W-2:0]} >= i_cfg.rear_count)) begin
            rear_load = '0;
        end else begin
            rear_load = i_rear_request[REAR_W-1:0];
        end
    end

    // Next state for one item.
    always_comb begin
        n_up_held      = r_up_held;
        n_down_held    = r_down_held;
        n_hold_done    = r_hold_done;
        n_hold_counter = r_hold_counter;
        n_front_pos    = r_front_pos;
        n_rear_pos     = r_rear_pos;
        shifted        = 1'b0;
        case (t_op'(i_op))
            OP_TICK: begin
                if ((r_up_held || r_down_held) && !r_hold_done) begin
                    n_hold_counter = count_inc;
                    if (count_inc >= i_cfg.hold_ticks) begin
                        // Long hold: front shift, up wins over down.
                        n_hold_counter = '0;
                        n_front_pos    = r_up_held ? front_dec : front_inc;
                        n_hold_done    = 1'b1;
                        shifted        = 1'b1;
                    end
                end
            end
            OP_UP_PRESS: begin
                if (!r_up_held) begin
                    n_up_held      = 1'b1;
                    n_hold_counter = '0;
                end
            end
            OP_UP_RELEASE: begin
                if (!r_hold_done) begin
                    n_rear_pos = rear_inc;
                    shifted    = 1'b1;
                end
                n_up_held   = 1'b0;
                n_hold_done = 1'b0;
            end
            OP_DOWN_PRESS: begin
                if (!r_down_held) begin
                    n_down_held    = 1'b1;
                    n_hold_counter = '0;
                end
            end
            OP_DOWN_RELEASE: begin
                if (!r_hold_done) begin
                    n_rear_pos = rear_dec;
                    shifted    = 1'b1;
                end
                n_down_held = 1'b0;
                n_hold_done = 1'b0;
            end
            OP_SET_GEAR: begin
                n_front_pos = front_load;
                n_rear_pos  = rear_load;
            end
            default: ;
        endcase
    end

    // State registers advance once per item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_held      <= 1'b0;
            r_down_held    <= 1'b0;
            r_hold_done    <= 1'b0;
            r_hold_counter <= '0;
            r_front_pos    <= FRONT_POS_RST;
            r_rear_pos     <= REAR_POS_RST;
        end else if (i_step) begin
            r_up_held      <= n_up_held;
            r_down_held    <= n_down_held;
            r_hold_done    <= n_hold_done;
            r_hold_counter <= n_hold_counter;
            r_front_pos    <= n_front_pos;
            r_rear_pos     <= n_rear_pos;
        end
    end

    // Result fields from the new positions; status from the current registers.
    always_comb begin
        gear_prod     = (FRONT_W+RCNT_W)'(n_front_pos) *
                        (FRONT_W+RCNT_W)'(i_cfg.rear_count);
        gear_sum      = {1'b0, gear_prod} + (FRONT_W+RCNT_W+1)'(n_rear_pos);
        o_gear_index  = gear_sum[GEAR_W-1:0];
        o_front_index = n_front_pos;
        o_rear_index  = n_rear_pos;
        o_shift_done  = shifted;
        o_status.up_held      = r_up_held;
        o_status.down_held    = r_down_held;
        o_status.hold_done    = r_hold_done;
        o_status.hold_counter = r_hold_counter;
    end

endmodule

/* src/press_hold_gear_shifter.sv */
// Channel   Dir  Beat contents (low bits first)
// s_axis    in   tuser: operation; tdata: front_request, rear_request
// m_axis    out  tdata: front_index, rear_index, gear_index, shift_done
// cfg       in   i_cfg_wr_en, i_cfg_index, i_cfg_data (no read-back)
//
// An input beat is registered, passes the combinational shifter core and lands
// in the output register.
// One beat per cycle is sustained while the output side accepts; the output register
// and the input register both hold a beat while the output side stalls.
// Reset is synchronous and active low; counts return to 3 and 10, the hold
// length to 200, and the gear to front 2, rear 9 with no button held.
`include "press_hold_gear_shifter_assert.svh"

module press_hold_gear_shifter
    import phgs_pkg::*;
#(
    parameter int MAX_FRONT = MAX_FRONT_DEF,
    parameter int MAX_REAR  = MAX_REAR_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // front_request, rear_request
    input  logic [OP_W-1:0]       s_axis_tuser,  // operation
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,  // front, rear, gear, shift_done
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg               cfg;
    t_status            status;
    logic               r_in_valid;
    logic [OP_W-1:0]    r_in_op;
    logic [FREQ_W-1:0]  r_in_freq;
    logic [RREQ_W-1:0]  r_in_rreq;
    logic               r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;
    logic               step;
    logic [FRONT_W-1:0] front_index;
    logic [REAR_W-1:0]  rear_index;
    logic [GEAR_W-1:0]  gear_index;
    logic               shift_done;

    // The input beat moves on when the output register is free or draining.
    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;

    phgs_cfg #(
        .MAX_FRONT (MAX_FRONT),
        .MAX_REAR  (MAX_REAR)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op   <= s_axis_tuser;
            r_in_freq <= s_axis_tdata[FREQ_W-1:0];
            r_in_rreq <= s_axis_tdata[FREQ_W+RREQ_W-1:FREQ_W];
        end
    end

    phgs_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_op            (r_in_op),
        .i_front_request (r_in_freq),
        .i_rear_request  (r_in_rreq),
        .i_cfg           (cfg),
        .o_front_index   (front_index),
        .o_rear_index    (rear_index),
        .o_gear_index    (gear_index),
        .o_shift_done    (shift_done),
        .o_status        (status)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= {shift_done, gear_index, rear_index, front_index};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // A finished long hold always belongs to a button that is still down.
    `PHGS_ASSERT_NOW(a_hold_done_held, i_clk, i_rst_n,
        status.hold_done, status.up_held || status.down_held)
    // The hold counter rests at zero once the front shift has happened.
    `PHGS_ASSERT_NOW(a_hold_done_count, i_clk, i_rst_n,
        status.hold_done, status.hold_counter == '0)
    // Every item that leaves the input register shows up as an output beat.
    `PHGS_ASSERT_NEXT(a_step_output, i_clk, i_rst_n, step, m_axis_tvalid)

endmodule

/* verif/press_hold_gear_shifter_tb.sv */
`timescale 1ns / 100ps

module press_hold_gear_shifter_tb;
    import phgs_pkg::*;

    // Operation codes the block does not define; they must leave the gear alone.
    localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

    // Cycles without any accepted beat before the run is declared hung.
    localparam int STALL_LIMIT = 5000;
    // Cycles allowed after the last expected beat has been seen.
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_LIMIT = 10;

    // One gear report as it leaves the block.
    typedef struct {
        logic [FRONT_W-1:0] front;
        logic [REAR_W-1:0]  rear;
        logic [GEAR_W-1:0]  gear;
        logic               shifted;
    } t_gear_report;

    // Tracks the shifter state and holds the gear reports still to come.
    class gear_tracker;
        logic [FRONT_W-1:0] front_count;
        logic [REAR_W-1:0]  rear_count;
        logic [HOLD_W-1:0]  hold_ticks;
        logic               up_held;
        logic               down_held;
        logic               hold_done;
        logic [HOLD_W-1:0]  hold_cnt;
        logic [FRONT_W-1:0] front_pos;
        logic [REAR_W-1:0]  rear_pos;
        t_gear_report       expected_reports[$];
        int                 errors;

        function new();
            front_count = FRONT_COUNT_RST;
            rear_count  = REAR_COUNT_RST;
            hold_ticks  = HOLD_TICKS_RST;
            up_held     = 1'b0;
            down_held   = 1'b0;
            hold_done   = 1'b0;
            hold_cnt    = '0;
            front_pos   = FRONT_POS_RST;
            rear_pos    = REAR_POS_RST;
            errors      = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_FRONT_COUNT: front_count = value[FRONT_W-1:0];
                CFG_REAR_COUNT:  rear_count  = value[REAR_W-1:0];
                CFG_HOLD_TICKS:  hold_ticks  = value[HOLD_W-1:0];
                default: ;
            endcase
        endfunction

        function int eff_count(int v, int maxv);
            if (v < 1) return 1;
            if (v > maxv) return maxv;
            return v;
        endfunction

        // Moving up pulls a position beyond the count back to count-1.
        function int step_up(int pos, int cnt);
            return (pos + 1 >= cnt) ? cnt - 1 : pos + 1;
        endfunction

        function int step_down(int pos);
            return (pos == 0) ? 0 : pos - 1;
        endfunction

        // A negative request or one at or beyond the count loads zero.
        function int requested_pos(logic signed [7:0] req, int cnt);
            if (req < 0 || req >= cnt) return 0;
            return int'(req);
        endfunction

        function void note_command(logic [OP_W-1:0] op, logic [FREQ_W-1:0] front_req,
                                   logic [RREQ_W-1:0] rear_req);
            int           fc;
            int           rc;
            int           gear_sum;
            logic         shifted;
            t_gear_report rpt;
            fc = eff_count(int'(front_count), MAX_FRONT_DEF);
            rc = eff_count(int'(rear_count), MAX_REAR_DEF);
            shifted = 1'b0;
            case (op)
                OP_TICK: begin
                    if ((up_held || down_held) && !hold_done) begin
                        hold_cnt = hold_cnt + HOLD_W'(1);
                        if (hold_cnt >= hold_ticks) begin
                            hold_cnt = '0;
                            if (up_held) begin
                                front_pos = FRONT_W'(step_down(int'(front_pos)));
                            end else begin
                                front_pos = FRONT_W'(step_up(int'(front_pos), fc));
                            end
                            hold_done = 1'b1;
                            shifted = 1'b1;
                        end
                    end
                end
                OP_UP_PRESS: begin
                    if (!up_held) begin
                        up_held = 1'b1;
                        hold_cnt = '0;
                    end
                end
                OP_UP_RELEASE: begin
                    if (!hold_done) begin
                        rear_pos = REAR_W'(step_up(int'(rear_pos), rc));
                        shifted = 1'b1;
                    end
                    up_held = 1'b0;
                    hold_done = 1'b0;
                end
                OP_DOWN_PRESS: begin
                    if (!down_held) begin
                        down_held = 1'b1;
                        hold_cnt = '0;
                    end
                end
                OP_DOWN_RELEASE: begin
                    if (!hold_done) begin
                        rear_pos = REAR_W'(step_down(int'(rear_pos)));
                        shifted = 1'b1;
                    end
                    down_held = 1'b0;
                    hold_done = 1'b0;
                end
                OP_SET_GEAR: begin
                    rear_pos  = REAR_W'(requested_pos(8'(signed'(rear_req)), rc));
                    front_pos = FRONT_W'(requested_pos(8'(signed'(front_req)), fc));
                end
                default: ;
            endcase
            gear_sum = int'(front_pos) * rc + int'(rear_pos);
            rpt.front = front_pos;
            rpt.rear = rear_pos;
            rpt.gear = gear_sum[GEAR_W-1:0];
            rpt.shifted = shifted;
            expected_reports.push_back(rpt);
        endfunction

        function void note_error(string what);
            if (errors < REPORT_LIMIT) $display("%s", what);
            errors++;
        endfunction

        function void check_report(logic [M_TDATA_W-1:0] beat);
            t_gear_report exp_rpt;
            t_gear_report got;
            got.front = beat[2:0];
            got.rear = beat[7:3];
            got.gear = beat[14:8];
            got.shifted = beat[15];
            if (expected_reports.size() == 0) begin
                note_error($sformatf("unexpected gear beat: front %0d rear %0d gear %0d shift %b",
                                     got.front, got.rear, got.gear, got.shifted));
                return;
            end
            exp_rpt = expected_reports.pop_front();
            if (got.front !== exp_rpt.front || got.rear !== exp_rpt.rear ||
                got.gear !== exp_rpt.gear || got.shifted !== exp_rpt.shifted) begin
                note_error($sformatf({"gear beat mismatch: expected front %0d rear %0d gear %0d ",
                                      "shift %b, got front %0d rear %0d gear %0d shift %b"},
                                     exp_rpt.front, exp_rpt.rear, exp_rpt.gear, exp_rpt.shifted,
                                     got.front, got.rear, got.gear, got.shifted));
            end
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;   // front_request, rear_request
    logic [OP_W-1:0]       s_axis_tuser = '0;   // operation
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;        // front, rear, gear, shift_done
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    gear_tracker tracker;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          stall_cycles = 0;

    press_hold_gear_shifter u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Output side backpressure.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Beat monitor and hang watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                tracker.note_command(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[9:4]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                tracker.check_report(m_axis_tdata);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Presents one command beat, after an optional random gap, and waits for it to be taken.
    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [FREQ_W-1:0] front_req,
                            input logic [RREQ_W-1:0] rear_req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {6'b0, rear_req, front_req};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Drops valid and waits until every expected gear beat has come out.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes all three registers on consecutive edges; upper data bits carry junk.
    task automatic apply_settings(input int front, input int rear, input int hold);
        logic [CFG_DATA_W-1:0] word;
        word = CFG_DATA_W'($urandom);
        word[FRONT_W-1:0] = FRONT_W'(front);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_FRONT_COUNT;
        i_cfg_data <= word;
        tracker.write_register(CFG_FRONT_COUNT, word);
        @(posedge i_clk);
        word = CFG_DATA_W'($urandom);
        word[REAR_W-1:0] = REAR_W'(rear);
        i_cfg_index <= CFG_REAR_COUNT;
        i_cfg_data <= word;
        tracker.write_register(CFG_REAR_COUNT, word);
        @(posedge i_clk);
        word = CFG_DATA_W'(hold);
        i_cfg_index <= CFG_HOLD_TICKS;
        i_cfg_data <= word;
        tracker.write_register(CFG_HOLD_TICKS, word);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic start_segment(input int send_pct, input int recv_pct, input int front,
                                 input int rear, input int hold);
        wait_idle();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        apply_settings(front, rear, hold);
    endtask

    // Mostly press, hold and release gestures with random length, plus gear sets and noise.
    task automatic run_random(input int target);
        int   sent;
        int   pick;
        int   ticks;
        int   cap;
        int   k;
        logic up_btn;
        begin
            sent = 0;
            while (sent < target) begin
                pick = $urandom_range(99);
                if (pick < 60) begin
                    up_btn = 1'($urandom_range(1));
                    cap = (int'(tracker.hold_ticks) < 10) ? int'(tracker.hold_ticks) + 2 : 8;
                    ticks = $urandom_range(cap);
                    send_cmd(up_btn ? OP_UP_PRESS : OP_DOWN_PRESS, 4'($urandom), 6'($urandom));
                    sent++;
                    for (k = 0; k < ticks; k++) begin
                        // Now and then the other button joins, or the same one is pressed again.
                        if ($urandom_range(9) == 0) begin
                            send_cmd((1'($urandom_range(1)) ^ up_btn) ? OP_UP_PRESS
                                                                      : OP_DOWN_PRESS,
                                     4'($urandom), 6'($urandom));
                            sent++;
                        end
                        send_cmd(OP_TICK, 4'($urandom), 6'($urandom));
                        sent++;
                    end
                    // Mostly the matching release, sometimes the wrong button's.
                    if ($urandom_range(9) == 0) up_btn = !up_btn;
                    send_cmd(up_btn ? OP_UP_RELEASE : OP_DOWN_RELEASE, 4'($urandom), 6'($urandom));
                    sent++;
                end else if (pick < 75) begin
                    if ($urandom_range(1)) begin
                        send_cmd(OP_SET_GEAR, 4'($urandom), 6'($urandom));
                    end else begin
                        send_cmd(OP_SET_GEAR, 4'($urandom_range(5)), 6'($urandom_range(20)));
                    end
                    sent++;
                end else begin
                    send_cmd(OP_W'($urandom), 4'($urandom), 6'($urandom));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        tracker = new();
        send_idle_pct = 17;
        recv_idle_pct = 55;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: releases without a press, unused codes, out-of-range gear sets.
        send_cmd(OP_UP_RELEASE, 4'($urandom), 6'($urandom));
        send_cmd(OP_DOWN_RELEASE, 4'($urandom), 6'($urandom));
        send_cmd(OP_UNUSED_6, 4'hF, 6'h3F);
        send_cmd(OP_UNUSED_7, 4'h0, 6'h00);
        send_cmd(OP_SET_GEAR, 4'd7, 6'h3F);
        send_cmd(OP_SET_GEAR, 4'h8, 6'h20);
        send_cmd(OP_SET_GEAR, 4'd2, 6'd9);

        // Widest counts, short hold: front shifts, up winning, repeated press, saturation.
        start_segment(17, 55, 5, 20, 2);
        send_cmd(OP_SET_GEAR, 4'd4, 6'd19);
        send_cmd(OP_UP_PRESS, 4'($urandom), 6'($urandom));
        send_cmd(OP_TICK, 4'($urandom), 6'($urandom));
        send_cmd(OP_TICK, 4'($urandom), 6'($urandom));
        send_cmd(OP_TICK, 4'($urandom), 6'($urandom));
        send_cmd(OP_UP_RELEASE, 4'($urandom), 6'($urandom));
        send_cmd(OP_UP_PRESS, 4'($urandom), 6'($urandom));
        send_cmd(OP_DOWN_PRESS, 4'($urandom), 6'($urandom));
        send_cmd(OP_TICK, 4'($urandom), 6'($urandom));
        send_cmd(OP_UP_PRESS, 4'($urandom), 6'($urandom));
        send_cmd(OP_TICK, 4'($urandom), 6'($urandom));
        send_cmd(OP_DOWN_RELEASE, 4'($urandom), 6'($urandom));
        send_cmd(OP_TICK, 4'($urandom), 6'($urandom));
        send_cmd(OP_TICK, 4'($urandom), 6'($urandom));
        send_cmd(OP_UP_RELEASE, 4'($urandom), 6'($urandom));
        send_cmd(OP_SET_GEAR, 4'd0, 6'd0);
        send_cmd(OP_UP_PRESS, 4'($urandom), 6'($urandom));
        send_cmd(OP_TICK, 4'($urandom), 6'($urandom));
        send_cmd(OP_TICK, 4'($urandom), 6'($urandom));
        send_cmd(OP_UP_RELEASE, 4'($urandom), 6'($urandom));

        // Random segments across settings; counts of zero and beyond the limits clamp.
        start_segment(17, 55, 5, 20, 3);
        run_random(80);
        start_segment(17, 55, 0, 0, 0);
        run_random(80);
        start_segment(55, 17, 7, 31, 1);
        run_random(80);
        start_segment(55, 17, 1, 1, 65535);
        run_random(80);
        start_segment(0, 0, 2, 7, 5);
        run_random(80);
        start_segment(0, 0, 4, 13, 2);
        run_random(80);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.pending() != 0) begin
            $display("%0d expected gear beats never arrived", tracker.pending());
            tracker.errors++;
        end
        if (tracker.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/phgs_pkg.sv
src/phgs_cfg.sv
src/phgs_core.sv
src/press_hold_gear_shifter.sv
verif/press_hold_gear_shifter_tb.sv
